@@ hw/rtl/cartridge_bank_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Bank controller assertion macros
// Shared property forms for the bank controller checks; clk and rst_n are
// taken from the scope that uses them.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

// Flag a condition that must never hold outside reset
`define CBC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// Require a consequence in the same cycle as its cause
`define CBC_ASSERT_IMPLY(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
    else $error(msg);

`endif

@@ hw/rtl/cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bank controller package
// Types, register indexes, route and region codes shared by the controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_MASK = 2'd2;

  // Result routes
  localparam logic [1:0] ROUTE_DATA = 2'd0;
  localparam logic [1:0] ROUTE_ROM  = 2'd1;
  localparam logic [1:0] ROUTE_SYS  = 2'd2;
  localparam logic [1:0] ROUTE_DONE = 2'd3;

  // Address regions, by the top three address bits
  localparam logic [2:0] REGION_RAM_EN  = 3'd0; // 0x0000-0x1FFF
  localparam logic [2:0] REGION_ROM_SEL = 3'd1; // 0x2000-0x3FFF
  localparam logic [2:0] REGION_RAM_SEL = 3'd2; // 0x4000-0x5FFF
  localparam logic [2:0] REGION_UNUSED  = 3'd3; // 0x6000-0x7FFF
  localparam logic [2:0] REGION_EXT_RAM = 3'd5; // 0xA000-0xBFFF

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] RAM_ERASED = 8'hFF;

  // Queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int OUT_DEPTH  = 4;

  // Classified access handed from front to back
  typedef struct packed {
    logic [1:0]  route;
    logic [22:0] ext_address;
    logic        rd_en;
    logic        wr_en;
    logic [7:0]  wdata;
  } cbc_cmd_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]  route;
    logic [7:0]  read_data;
    logic [22:0] ext_address;
  } cbc_res_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic issue;
  } cbc_stat_t;

endpackage

@@ hw/rtl/cbc_front.sv @@
// ----------------------------------------------------------------------------
// Bank controller front end
// Holds configuration and bank registers, decodes each access and issues a
// classified command towards the back end.
// ----------------------------------------------------------------------------
module cbc_front
  import cbc_pkg::*;
#(
  parameter int RAM_BYTES     = 131072,
  parameter int ROM_BANK_BITS = 9,
  localparam int AW           = $clog2(RAM_BYTES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_req_type,
  input  logic [15:0]           in_address,
  input  logic [7:0]            in_write_data,
  input  logic                  stall,
  output logic                  q_push,
  output cbc_cmd_t              q_cmd,
  output logic [AW-1:0]         q_idx
);

  logic                     ram_present_r,   ram_present_nxt;
  logic [8:0]               rom_bank_mask_r, rom_bank_mask_nxt;
  logic [3:0]               ram_bank_mask_r, ram_bank_mask_nxt;
  logic                     ram_enabled_r,   ram_enabled_nxt;
  logic [ROM_BANK_BITS-1:0] rom_bank_r,      rom_bank_nxt;
  logic                     rom_bank_high_r, rom_bank_high_nxt;
  logic [3:0]               ram_bank_r,      ram_bank_nxt;

  logic                     accept;
  logic [2:0]               region;
  logic [8:0]               rom_bank_wide;
  logic [8:0]               rom_cand;

  assign accept  = in_push && !in_full;
  assign in_full = stall;
  assign q_push  = accept;
  assign region  = in_address[15:13];
  assign rom_bank_wide = 9'(rom_bank_r);

  // Configuration writes
  always_comb begin
    ram_present_nxt   = ram_present_r;
    rom_bank_mask_nxt = rom_bank_mask_r;
    ram_bank_mask_nxt = ram_bank_mask_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAM_PRESENT:   ram_present_nxt   = cfg_data[0];
        CFG_ROM_BANK_MASK: rom_bank_mask_nxt = cfg_data;
        CFG_RAM_BANK_MASK: ram_bank_mask_nxt = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Bank register updates on control writes
  always_comb begin
    ram_enabled_nxt   = ram_enabled_r;
    rom_bank_nxt      = rom_bank_r;
    rom_bank_high_nxt = rom_bank_high_r;
    ram_bank_nxt      = ram_bank_r;
    rom_cand          = {rom_bank_high_r, in_write_data};
    if (accept && in_req_type) begin
      unique case (region)
        REGION_RAM_EN: begin
          if (ram_present_r) ram_enabled_nxt = (in_write_data[3:0] == RAM_EN_KEY);
        end
        REGION_ROM_SEL: begin
          if (!in_address[12]) begin
            rom_cand = {rom_bank_high_r, in_write_data};
          end else begin
            rom_bank_high_nxt = in_write_data[0];
            rom_cand          = {in_write_data[0], rom_bank_wide[7:0]};
          end
          rom_bank_nxt = rom_cand[ROM_BANK_BITS-1:0] & rom_bank_mask_r[ROM_BANK_BITS-1:0];
        end
        REGION_RAM_SEL: ram_bank_nxt = in_write_data[3:0] & ram_bank_mask_r;
        default: ;
      endcase
    end
  end

  // Banked RAM index, reduced modulo the RAM size by conditional subtraction
  always_comb begin
    logic [17:0] v;
    v = {1'b0, ram_bank_r, in_address[12:0]};
    for (int k = 3; k >= 0; k--) begin
      if (v >= (18'(RAM_BYTES) << k)) v = v - (18'(RAM_BYTES) << k);
    end
    q_idx = v[AW-1:0];
  end

  // Classify the access
  always_comb begin
    q_cmd             = '0;
    q_cmd.route       = ROUTE_SYS;
    q_cmd.ext_address = 23'(in_address);
    q_cmd.wdata       = in_write_data;
    if (!in_req_type) begin
      unique case (region)
        REGION_RAM_SEL, REGION_UNUSED: begin
          q_cmd.route       = ROUTE_ROM;
          q_cmd.ext_address = {rom_bank_wide, in_address[13:0]};
        end
        REGION_EXT_RAM: begin
          q_cmd.route       = ROUTE_DATA;
          q_cmd.ext_address = '0;
          q_cmd.rd_en       = ram_enabled_r;
        end
        default: ;
      endcase
    end else begin
      unique case (region)
        REGION_RAM_EN, REGION_ROM_SEL, REGION_RAM_SEL, REGION_UNUSED: begin
          q_cmd.route       = ROUTE_DONE;
          q_cmd.ext_address = '0;
        end
        REGION_EXT_RAM: begin
          q_cmd.route       = ROUTE_DONE;
          q_cmd.ext_address = '0;
          q_cmd.wr_en       = ram_enabled_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_present_r   <= 1'b0;
      rom_bank_mask_r <= 9'h1FF;
      ram_bank_mask_r <= 4'hF;
      ram_enabled_r   <= 1'b0;
      rom_bank_r      <= ROM_BANK_BITS'(1);
      rom_bank_high_r <= 1'b0;
      ram_bank_r      <= 4'h0;
    end else begin
      ram_present_r   <= ram_present_nxt;
      rom_bank_mask_r <= rom_bank_mask_nxt;
      ram_bank_mask_r <= ram_bank_mask_nxt;
      ram_enabled_r   <= ram_enabled_nxt;
      rom_bank_r      <= rom_bank_nxt;
      rom_bank_high_r <= rom_bank_high_nxt;
      ram_bank_r      <= ram_bank_nxt;
    end
  end

endmodule

@@ hw/rtl/cbc_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// Bank controller command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module cbc_cmd_queue
  import cbc_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] data_in,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] data_out,
  output logic         empty
);

  localparam int PW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  logic [W-1:0]  slot_r [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(CMDQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= data_in;
  end

endmodule

@@ hw/rtl/cbc_back.sv @@
// ----------------------------------------------------------------------------
// Bank controller back end
// Owns the banked RAM: clears it after reset, carries out RAM reads and
// writes and buffers the result transactions.
// ----------------------------------------------------------------------------
module cbc_back
  import cbc_pkg::*;
#(
  parameter int RAM_BYTES = 131072,
  localparam int AW       = $clog2(RAM_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cbc_cmd_t      q_cmd,
  input  logic [AW-1:0] q_idx,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [1:0]    out_route,
  output logic [7:0]    out_read_data,
  output logic [22:0]   out_ext_address,
  output cbc_stat_t     stat
);

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic [7:0]    bank_ram_r [RAM_BYTES];
  logic [7:0]    ram_q_r;
  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_idx_r,  clr_idx_nxt;
  logic          s1_valid_r;
  cbc_cmd_t      s1_cmd_r;
  cbc_res_t      out_slot_r [OUT_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic [CW-1:0] occupancy;
  logic          issue;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wd;
  logic          do_pop;
  cbc_res_t      res;
  cbc_res_t      head;

  // Issue only with room for the result in flight
  assign occupancy = cnt_r + CW'(s1_valid_r);
  assign issue     = !clearing_r && !q_empty && (occupancy < CW'(OUT_DEPTH));
  assign q_pop     = issue;

  assign stat.clearing = clearing_r;
  assign stat.issue    = issue;

  // Sweep the RAM with the erased value after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      if (clr_idx_r == AW'(RAM_BYTES - 1)) clearing_nxt = 1'b0;
      else                                 clr_idx_nxt  = clr_idx_r + 1'b1;
    end
  end

  // RAM port: sweep or command
  assign ram_addr = clearing_r ? clr_idx_r : q_idx;
  assign ram_we   = clearing_r || (issue && q_cmd.wr_en);
  assign ram_wd   = clearing_r ? RAM_ERASED : q_cmd.wdata;

  always_ff @(posedge clk) begin
    if (ram_we) bank_ram_r[ram_addr] <= ram_wd;
    ram_q_r <= bank_ram_r[ram_addr];
  end

  // Form the result once the RAM data is back
  always_comb begin
    res.route       = s1_cmd_r.route;
    res.ext_address = s1_cmd_r.ext_address;
    if (s1_cmd_r.rd_en)                  res.read_data = ram_q_r;
    else if (s1_cmd_r.route == ROUTE_DATA) res.read_data = RAM_ERASED;
    else                                 res.read_data = '0;
  end

  // Result buffer
  assign out_empty       = (cnt_r == '0);
  assign do_pop          = out_pop && !out_empty;
  assign head            = out_slot_r[rd_ptr_r];
  assign out_route       = head.route;
  assign out_read_data   = head.read_data;
  assign out_ext_address = head.ext_address;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (s1_valid_r) wr_ptr_nxt = (wr_ptr_r == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)     rd_ptr_nxt = (rd_ptr_r == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (s1_valid_r && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!s1_valid_r && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      s1_valid_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
      s1_valid_r <= issue;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Hold payload of the stage and buffer
  always_ff @(posedge clk) begin
    if (issue)      s1_cmd_r <= q_cmd;
    if (s1_valid_r) out_slot_r[wr_ptr_r] <= res;
  end

endmodule

@@ hw/rtl/cartridge_bank_controller.sv @@
// Path to the out_ ports: command queue, back-end RAM stage, result buffer.
// Throughput: one access per cycle while out_pop keeps up (single RAM port).
// Reset: synchronous, active low; bank and configuration registers take defaults.
// After reset the banked RAM is swept to 0xFF, one byte a cycle, over all
// RAM_BYTES bytes (131072 by default); in_full stays high until the sweep ends.
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Decodes CPU bus accesses into bank register updates, banked ROM fetch
// addresses, banked RAM accesses and pass-through transactions.
// ----------------------------------------------------------------------------
`include "cartridge_bank_controller_assert.svh"

module cartridge_bank_controller
  import cbc_pkg::*;
#(
  parameter int RAM_BYTES     = 131072,
  parameter int ROM_BANK_BITS = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_req_type,
  input  logic [15:0]           in_address,
  input  logic [7:0]            in_write_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [1:0]            out_route,
  output logic [7:0]            out_read_data,
  output logic [22:0]           out_ext_address
);

  localparam int AW = $clog2(RAM_BYTES);
  localparam int QW = $bits(cbc_cmd_t) + AW;

  logic          q_push, q_full, q_pop, q_empty;
  cbc_cmd_t      fr_cmd, bk_cmd;
  logic [AW-1:0] fr_idx, bk_idx;
  cbc_stat_t     bk_stat;

  // Decode and bank registers
  cbc_front #(
    .RAM_BYTES     (RAM_BYTES),
    .ROM_BANK_BITS (ROM_BANK_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_req_type   (in_req_type),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .stall         (q_full || bk_stat.clearing),
    .q_push        (q_push),
    .q_cmd         (fr_cmd),
    .q_idx         (fr_idx)
  );

  // Command queue
  cbc_cmd_queue #(
    .W (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .data_in  ({fr_cmd, fr_idx}),
    .full     (q_full),
    .pop      (q_pop),
    .data_out ({bk_cmd, bk_idx}),
    .empty    (q_empty)
  );

  // Banked RAM and result buffer
  cbc_back #(
    .RAM_BYTES (RAM_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (bk_cmd),
    .q_idx           (bk_idx),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_route       (out_route),
    .out_read_data   (out_read_data),
    .out_ext_address (out_ext_address),
    .stat            (bk_stat)
  );

  // Checks
  `CBC_ASSERT_IMPLY(a_full_while_clearing, bk_stat.clearing, in_full,
                    "access accepted during RAM sweep")
  `CBC_ASSERT_IMPLY(a_sweep_after_reset, $past(!rst_n), bk_stat.clearing,
                    "RAM sweep not started after reset")
  `CBC_ASSERT_NEVER(a_queue_overrun, q_push && q_full, "command queue overrun")
  `CBC_ASSERT_NEVER(a_issue_when_empty, bk_stat.issue && q_empty,
                    "back end issued from an empty queue")

endmodule

@@ tb/sv/cartridge_bank_controller_test.sv @@
// ----------------------------------------------------------------------------
// Bank controller testbench
// Drives CPU bus accesses into the controller through its queue-style ports.
// Every accepted access is decoded by a behavioural copy of the bank logic,
// and each popped transaction is checked field by field against it, or against
// the typed result of a directed row. A short table of directed accesses comes
// first, then random bursts under several register settings, with random gaps
// on the push side and stalls on the pop side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cartridge_bank_controller_test;
  import cbc_pkg::*;

  localparam int ITEMS_PER_PHASE = 270;
  localparam int N_PHASES        = 6;

  typedef enum {POP_FREE, POP_HALF, POP_SPARSE, POP_HOLD} pop_mode_t;

  // One row of the directed table: a register write or a bus access
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  is_wr;
    logic [15:0]           addr;
    logic [7:0]            wdata;
    bit                    typed;
    cbc_res_t              res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_req_type = 1'b0;
  logic [15:0]           in_address = '0;
  logic [7:0]            in_write_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [1:0]            out_route;
  logic [7:0]            out_read_data;
  logic [22:0]           out_ext_address;

  // Tag for directed accesses whose result is typed into the table
  bit       typed_on = 1'b0;
  cbc_res_t typed_res = '0;

  // Shadow of the configuration registers
  logic       cfg_ram_present = 1'b0;
  logic [8:0] cfg_rom_mask = 9'h1FF;
  logic [3:0] cfg_ram_mask = 4'hF;

  // Shadow of the bank state; unwritten RAM bytes read as erased
  logic       ram_en = 1'b0;
  logic [8:0] rom_bank = 9'd1;
  logic       rom_high = 1'b0;
  logic [3:0] ram_bank = 4'd0;
  logic [7:0] ram_shadow [int];

  cbc_res_t  pending_results[$];
  stim_row_t stim_table[$];
  int        err_count = 0;
  int        burst_left = 0;
  pop_mode_t pop_mode = POP_FREE;
  int        pop_run = 0;

  cartridge_bank_controller dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_address      (in_address),
    .in_write_data   (in_write_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_route       (out_route),
    .out_read_data   (out_read_data),
    .out_ext_address (out_ext_address)
  );

  always #10 clk = ~clk;

  // Decode one access against the shadow state and advance it
  function automatic cbc_res_t bank_decode(logic is_wr, logic [15:0] addr, logic [7:0] wd);
    cbc_res_t r;
    int       idx;
    r.route       = ROUTE_SYS;
    r.read_data   = '0;
    r.ext_address = {7'd0, addr};
    idx = int'({ram_bank, addr[12:0]});
    if (!is_wr) begin
      case (addr[15:13])
        REGION_RAM_SEL, REGION_UNUSED: begin
          r.route       = ROUTE_ROM;
          r.ext_address = {rom_bank, addr[13:0]};
        end
        REGION_EXT_RAM: begin
          r.route       = ROUTE_DATA;
          r.ext_address = '0;
          r.read_data   = (ram_en && ram_shadow.exists(idx)) ? ram_shadow[idx] : RAM_ERASED;
        end
        default: ;
      endcase
    end else begin
      r.route       = ROUTE_DONE;
      r.ext_address = '0;
      case (addr[15:13])
        REGION_RAM_EN: begin
          if (cfg_ram_present) ram_en = (wd[3:0] == RAM_EN_KEY);
        end
        REGION_ROM_SEL: begin
          if (!addr[12]) begin
            rom_bank = {rom_high, wd} & cfg_rom_mask;
          end else begin
            rom_high = wd[0];
            rom_bank = {rom_high, rom_bank[7:0]} & cfg_rom_mask;
          end
        end
        REGION_RAM_SEL: ram_bank = wd[3:0] & cfg_ram_mask;
        REGION_UNUSED: ;
        REGION_EXT_RAM: begin
          if (ram_en) ram_shadow[idx] = wd;
        end
        default: begin
          r.route       = ROUTE_SYS;
          r.ext_address = {7'd0, addr};
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [22:0] got, logic [22:0] want);
    $display("%0t MISMATCH %s: got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    stim_table.push_back(row);
  endtask

  task automatic add_access(logic is_wr, logic [15:0] addr, logic [7:0] wd, bit typed,
                            logic [1:0] route, logic [7:0] rdata, logic [22:0] ext);
    stim_row_t row;
    row       = '{default: '0};
    row.is_wr = is_wr;
    row.addr  = addr;
    row.wdata = wd;
    row.typed = typed;
    row.res   = '{route: route, read_data: rdata, ext_address: ext};
    stim_table.push_back(row);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Push one access, in bursts separated by random gaps
  task automatic send_access(logic is_wr, logic [15:0] addr, logic [7:0] wd,
                             bit typed, cbc_res_t tres);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk) in_push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_push       <= 1'b1;
    in_req_type   <= is_wr;
    in_address    <= addr;
    in_write_data <= wd;
    typed_on      <= typed;
    typed_res     <= tres;
    do @(posedge clk); while (in_full);
  endtask

  // Drop push and wait until every expected transaction has been popped
  task automatic settle_results();
    @(negedge clk) in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pop side: stall on a pattern that changes from run to run
  always @(negedge clk) begin
    if (pop_run == 0) begin
      pop_mode = pop_mode_t'($urandom_range(0, 3));
      pop_run  = $urandom_range(4, 40);
    end
    pop_run--;
    case (pop_mode)
      POP_FREE:   out_pop <= 1'b1;
      POP_HALF:   out_pop <= 1'($urandom_range(0, 1));
      POP_SPARSE: out_pop <= ($urandom_range(0, 3) == 0);
      default:    out_pop <= 1'b0;
    endcase
  end

  // Sample register writes and both handshakes at the rising edge
  always @(posedge clk) begin
    cbc_res_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RAM_PRESENT:   cfg_ram_present = cfg_data[0];
          CFG_ROM_BANK_MASK: cfg_rom_mask    = cfg_data[8:0];
          CFG_RAM_BANK_MASK: cfg_ram_mask    = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transaction, route", 23'(out_route), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_route !== want.route)
            report_mismatch("route", 23'(out_route), 23'(want.route));
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", 23'(out_read_data), 23'(want.read_data));
          if (out_ext_address !== want.ext_address)
            report_mismatch("ext_address", out_ext_address, want.ext_address);
        end
      end
      if (in_push && !in_full) begin
        want = bank_decode(in_req_type, in_address, in_write_data);
        pending_results.push_back(typed_on ? typed_res : want);
      end
    end
  end

  initial begin
    int        sel;
    logic      is_wr;
    logic [15:0] addr;
    logic [7:0]  wd;
    cbc_res_t  none;
    int        phase_present [N_PHASES];
    int        phase_rom_mask [N_PHASES];
    int        phase_ram_mask [N_PHASES];
    int        rom_m;
    int        ram_m;

    none           = '0;
    phase_present  = '{1, 1, 0, 1, 1, 1};
    phase_rom_mask = '{511, 0, 511, 31, 0, 511};
    phase_ram_mask = '{15, 0, 15, 3, 0, 15};

    // Defaults first: no RAM fitted, so the enable write must not take
    add_cfg(CFG_RAM_PRESENT, 9'd0);
    add_cfg(CFG_ROM_BANK_MASK, 9'h1FF);
    add_cfg(CFG_RAM_BANK_MASK, 9'h00F);
    add_access(1'b0, 16'h4000, 8'h00, 1, ROUTE_ROM,  8'h00, 23'h004000);
    add_access(1'b0, 16'h7FFF, 8'hFF, 1, ROUTE_ROM,  8'h00, 23'h007FFF);
    add_access(1'b0, 16'hA000, 8'h00, 1, ROUTE_DATA, 8'hFF, 23'h000000);
    add_access(1'b1, 16'h0000, 8'h0A, 1, ROUTE_DONE, 8'h00, 23'h000000);
    add_access(1'b0, 16'hBFFF, 8'h00, 1, ROUTE_DATA, 8'hFF, 23'h000000);
    add_access(1'b0, 16'h0000, 8'h00, 1, ROUTE_SYS,  8'h00, 23'h000000);
    add_access(1'b1, 16'hFFFF, 8'hFF, 1, ROUTE_SYS,  8'h00, 23'h00FFFF);
    add_access(1'b1, 16'h6000, 8'h55, 1, ROUTE_DONE, 8'h00, 23'h000000);
    // RAM fitted: enable, write at both ends of the window and read back the low end
    add_cfg(CFG_RAM_PRESENT, 9'd1);
    add_access(1'b1, 16'h1FFF, 8'hFA, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'hA000, 8'h00, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'hBFFF, 8'hFF, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b0, 16'hA000, 8'h00, 0, ROUTE_DATA, 8'h00, 23'h0);
    // Top ROM bank gives the widest fetch address, then bank 0
    add_access(1'b1, 16'h2000, 8'hFF, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'h3000, 8'h01, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b0, 16'h7FFF, 8'h00, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'h2FFF, 8'h00, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'h3FFF, 8'hFE, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b0, 16'h4000, 8'h00, 0, ROUTE_DATA, 8'h00, 23'h0);
    // Top RAM bank, then disable (reads erased, writes dropped) and enable again
    add_access(1'b1, 16'h5FFF, 8'hFF, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'hA123, 8'h5A, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'h0000, 8'h0B, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'hA123, 8'h77, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b0, 16'hA123, 8'h00, 1, ROUTE_DATA, 8'hFF, 23'h000000);
    add_access(1'b1, 16'h0000, 8'hFA, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b0, 16'hA123, 8'h00, 0, ROUTE_DATA, 8'h00, 23'h0);
    // Narrow masks: stored banks hold until rewritten
    add_cfg(CFG_ROM_BANK_MASK, 9'd3);
    add_cfg(CFG_RAM_BANK_MASK, 9'd1);
    add_access(1'b0, 16'h4000, 8'h00, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'h2000, 8'hFF, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b0, 16'h6ABC, 8'h00, 0, ROUTE_DATA, 8'h00, 23'h0);
    add_access(1'b1, 16'h4000, 8'h0F, 0, ROUTE_DATA, 8'h00, 23'h0);

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Walk the directed table
    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        settle_results();
        write_reg(stim_table[i].idx, stim_table[i].val);
      end else begin
        send_access(stim_table[i].is_wr, stim_table[i].addr, stim_table[i].wdata,
                    stim_table[i].typed, stim_table[i].res);
      end
    end

    // Random bursts, one register setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      rom_m = phase_rom_mask[p];
      ram_m = phase_ram_mask[p];
      if (p == 4) begin
        rom_m = $urandom_range(0, 511);
        ram_m = $urandom_range(0, 15);
      end
      settle_results();
      write_reg(CFG_RAM_PRESENT, 9'(phase_present[p]));
      write_reg(CFG_ROM_BANK_MASK, 9'(rom_m));
      write_reg(CFG_RAM_BANK_MASK, 9'(ram_m));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel   = $urandom_range(0, 99);
        is_wr = 1'b1;
        wd    = 8'($urandom);
        if (sel < 12) begin
          // RAM enable, mostly with the key so the RAM stays reachable
          addr = {3'b000, 13'($urandom)};
          if ($urandom_range(0, 9) < 7) wd = {4'($urandom), RAM_EN_KEY};
        end else if (sel < 22) begin
          addr = {4'b0010, 12'($urandom)};
        end else if (sel < 27) begin
          addr = {4'b0011, 12'($urandom)};
        end else if (sel < 35) begin
          addr = {3'b010, 13'($urandom)};
        end else if (sel < 38) begin
          addr = {3'b011, 13'($urandom)};
        end else if (sel < 78) begin
          // Banked RAM, mostly a small cluster so reads hit earlier writes
          addr  = {3'b101, ($urandom_range(0, 9) < 6) ? {9'd0, 4'($urandom)}
                                                      : 13'($urandom)};
          is_wr = (sel < 58);
        end else if (sel < 90) begin
          addr  = {2'b01, 14'($urandom)};
          is_wr = 1'b0;
        end else begin
          addr  = 16'($urandom);
          is_wr = 1'($urandom);
        end
        send_access(is_wr, addr, wd, 1'b0, none);
      end
    end

    settle_results();
    if (pending_results.size() != 0)
      report_mismatch("transactions outstanding", 23'(pending_results.size()), '0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: covers the post-reset RAM sweep and the slowest stall patterns
  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ cartridge_bank_controller.f @@
+incdir+hw/rtl
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_front.sv
hw/rtl/cbc_cmd_queue.sv
hw/rtl/cbc_back.sv
hw/rtl/cartridge_bank_controller.sv
tb/sv/cartridge_bank_controller_test.sv
